// ===== rtl/core/vsfb_pkg.sv =====
// Shared types, constants and lookup functions for the voltage segment frame builder.
`default_nettype none

package vsfb_pkg;

  localparam int unsigned VoltW   = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BrightW = 3;
  localparam int unsigned DigitW  = 4;

  localparam logic [VoltW-1:0] VoltMax = 10'd999;

  localparam logic [ByteW-1:0] GridCmdBase = 8'hC0;
  localparam logic [ByteW-1:0] CtrlCmdBase = 8'h88;
  localparam logic [ByteW-1:0] BlankSegs   = 8'h00;

  // Configuration register indexes
  localparam logic CfgBrightness = 1'b0;
  localparam logic CfgFixedAddr  = 1'b1;

  localparam logic [BrightW-1:0] BrightnessRst = 3'd7;
  localparam logic [ByteW-1:0]   FixedAddrRst  = 8'h44;

  // Segment bytes of the three digits, hundreds first
  typedef struct packed {
    logic [ByteW-1:0] seg_h;
    logic [ByteW-1:0] seg_t;
    logic [ByteW-1:0] seg_u;
  } frame_t;

  function automatic logic [ByteW-1:0] seg_of(input logic [DigitW-1:0] digit);
    logic [ByteW-1:0] seg;
    case (digit)
      4'd0:    seg = 8'b11011110;
      4'd1:    seg = 8'b00010010;
      4'd2:    seg = 8'b10101110;
      4'd3:    seg = 8'b10111010;
      4'd4:    seg = 8'b01110010;
      4'd5:    seg = 8'b11111000;
      4'd6:    seg = 8'b11111100;
      4'd7:    seg = 8'b10010010;
      4'd8:    seg = 8'b11111110;
      4'd9:    seg = 8'b11111010;
      default: seg = BlankSegs;
    endcase
    return seg;
  endfunction

  // Grid address command for digit position idx (0 = hundreds)
  function automatic logic [ByteW-1:0] grid_cmd(input logic sel_in, input logic [1:0] idx);
    logic [2:0] grid;
    case (idx)
      2'd0:    grid = sel_in ? 3'd5 : 3'd2;
      2'd1:    grid = sel_in ? 3'd3 : 3'd1;
      2'd2:    grid = sel_in ? 3'd4 : 3'd0;
      default: grid = 3'd0;
    endcase
    return GridCmdBase | {5'd0, grid};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vsfb_digit_split.sv =====
// Splits a voltage into decimal digits, blanks leading zeros and maps to segment bytes.
`default_nettype none

module vsfb_digit_split (
  input  wire logic [vsfb_pkg::VoltW-1:0] voltage_i,
  output vsfb_pkg::frame_t                frame_o,
  output logic                            in_range_o
);

  logic [15:0]                     prod_h;
  logic [vsfb_pkg::DigitW-1:0]     dig_h;
  logic [vsfb_pkg::VoltW-1:0]      hund_part;
  logic [vsfb_pkg::VoltW-1:0]      rem_full;
  logic [6:0]                      rem;
  logic [14:0]                     prod_t;
  logic [vsfb_pkg::DigitW-1:0]     dig_t;
  logic [6:0]                      tens_part;
  logic [6:0]                      unit_full;
  logic [vsfb_pkg::DigitW-1:0]     dig_u;

  // Divide by 100 and by 10 through reciprocal multiplies, exact over the valid range
  assign prod_h    = 16'(voltage_i) * 16'd41;
  assign dig_h     = prod_h[15:12];
  assign hund_part = 10'(dig_h) * 10'd100;
  assign rem_full  = voltage_i - hund_part;
  assign rem       = rem_full[6:0];
  assign prod_t    = 15'(rem) * 15'd205;
  assign dig_t     = prod_t[14:11];
  assign tens_part = 7'(dig_t) * 7'd10;
  assign unit_full = rem - tens_part;
  assign dig_u     = unit_full[3:0];

  assign in_range_o = (voltage_i <= vsfb_pkg::VoltMax);

  always_comb begin
    frame_o.seg_h = vsfb_pkg::seg_of(dig_h);
    frame_o.seg_t = vsfb_pkg::seg_of(dig_t);
    frame_o.seg_u = vsfb_pkg::seg_of(dig_u);
    if (dig_h == '0) begin
      frame_o.seg_h = vsfb_pkg::BlankSegs;
      if (dig_t == '0) begin
        frame_o.seg_t = vsfb_pkg::BlankSegs;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/voltage_segment_frame_builder_core.sv =====
// Top level: input register, digit decode and eight-beat display frame serializer.
//
// Each accepted voltage (0..999) yields eight output beats: the fixed-address
// command, then grid address and segment byte for hundreds, tens and units, then
// the display-control byte 0x88 + brightness. Voltages above 999 are accepted
// and dropped with no output. The output serializer sends one beat per cycle
// while out_ready_i is high; a low out_ready_i holds the current beat. The input
// register takes the next item while a frame is still being sent, and its
// decoded frame loads in the cycle the last beat of the previous one is taken.
// Configuration writes land at once and apply to all beats sent afterwards.
`default_nettype none

module voltage_segment_frame_builder_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_idx_i,
  input  wire logic [vsfb_pkg::ByteW-1:0]         cfg_wdata_i,

  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [vsfb_pkg::VoltW-1:0]         voltage_i,
  input  wire logic                               screen_select_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [vsfb_pkg::ByteW-1:0]              bus_byte_o,
  output logic                                    start_before_o,
  output logic                                    stop_after_o,
  output logic                                    last_byte_o
);

  localparam logic [2:0] BeatCmd   = 3'd0;
  localparam logic [2:0] BeatGridH = 3'd1;
  localparam logic [2:0] BeatSegH  = 3'd2;
  localparam logic [2:0] BeatGridT = 3'd3;
  localparam logic [2:0] BeatSegT  = 3'd4;
  localparam logic [2:0] BeatGridU = 3'd5;
  localparam logic [2:0] BeatSegU  = 3'd6;
  localparam logic [2:0] BeatCtrl  = 3'd7;

  logic [vsfb_pkg::BrightW-1:0] bright_q;
  logic [vsfb_pkg::ByteW-1:0]   fixed_cmd_q;

  logic                         a_valid_q;
  logic [vsfb_pkg::VoltW-1:0]   a_volt_q;
  logic                         a_sel_q;

  logic                         b_valid_q;
  logic [2:0]                   beat_q;
  logic                         b_sel_q;
  vsfb_pkg::frame_t             b_frame_q;

  vsfb_pkg::frame_t             dec_frame;
  logic                         dec_in_range;

  logic                         in_fire;
  logic                         out_fire;
  logic                         b_done;
  logic                         b_free;
  logic                         a_leave;
  logic                         b_load;

  vsfb_digit_split u_split (
    .voltage_i  (a_volt_q),
    .frame_o    (dec_frame),
    .in_range_o (dec_in_range)
  );

  assign out_fire   = out_valid_o && out_ready_i;
  assign b_done     = out_fire && (beat_q == BeatCtrl);
  assign b_free     = !b_valid_q || b_done;
  assign a_leave    = a_valid_q && (!dec_in_range || b_free);
  assign b_load     = a_valid_q && dec_in_range && b_free;
  assign in_ready_o = !a_valid_q || a_leave;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q    <= vsfb_pkg::BrightnessRst;
      fixed_cmd_q <= vsfb_pkg::FixedAddrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vsfb_pkg::CfgBrightness: bright_q    <= cfg_wdata_i[vsfb_pkg::BrightW-1:0];
        vsfb_pkg::CfgFixedAddr:  fixed_cmd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_volt_q <= voltage_i;
      a_sel_q  <= screen_select_i;
    end
  end

  // Frame register and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      beat_q    <= BeatCmd;
    end else if (b_load) begin
      b_valid_q <= 1'b1;
      beat_q    <= BeatCmd;
    end else if (b_done) begin
      b_valid_q <= 1'b0;
      beat_q    <= BeatCmd;
    end else if (out_fire) begin
      beat_q    <= beat_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_frame_q <= dec_frame;
      b_sel_q   <= a_sel_q;
    end
  end

  assign out_valid_o = b_valid_q;

  always_comb begin
    bus_byte_o     = fixed_cmd_q;
    start_before_o = 1'b1;
    stop_after_o   = 1'b1;
    last_byte_o    = 1'b0;
    case (beat_q)
      BeatCmd: begin
        bus_byte_o = fixed_cmd_q;
      end
      BeatGridH, BeatGridT, BeatGridU: begin
        bus_byte_o   = vsfb_pkg::grid_cmd(b_sel_q, beat_q[2:1]);
        stop_after_o = 1'b0;
      end
      BeatSegH: begin
        bus_byte_o     = b_frame_q.seg_h;
        start_before_o = 1'b0;
      end
      BeatSegT: begin
        bus_byte_o     = b_frame_q.seg_t;
        start_before_o = 1'b0;
      end
      BeatSegU: begin
        bus_byte_o     = b_frame_q.seg_u;
        start_before_o = 1'b0;
      end
      BeatCtrl: begin
        bus_byte_o  = vsfb_pkg::CtrlCmdBase + {5'd0, bright_q};
        last_byte_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== dv/vsfb_checker.sv =====
// Frame checker: predicts the eight bus beats of each in-range voltage and compares them in order.
`timescale 1ns / 1ps

module vsfb_checker
  import vsfb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_wdata_i,

  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [VoltW-1:0]   voltage_i,
  input  wire logic               screen_select_i,

  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [ByteW-1:0]   bus_byte_i,
  input  wire logic               start_before_i,
  input  wire logic               stop_after_i,
  input  wire logic               last_byte_i,

  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             start_b;
    logic             stop_a;
    logic             last;
  } bus_beat_t;

  bus_beat_t          frame_beats_q[$];
  logic [BrightW-1:0] brightness;
  logic [ByteW-1:0]   fixed_cmd;
  int                 mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic [ByteW-1:0] seg_pattern(input int digit);
    logic [ByteW-1:0] pat;
    case (digit)
      0:       pat = 8'hDE;
      1:       pat = 8'h12;
      2:       pat = 8'hAE;
      3:       pat = 8'hBA;
      4:       pat = 8'h72;
      5:       pat = 8'hF8;
      6:       pat = 8'hFC;
      7:       pat = 8'h92;
      8:       pat = 8'hFE;
      default: pat = 8'hFA;
    endcase
    return pat;
  endfunction

  // Grid number of digit position pos (0 = hundreds) on the selected screen
  function automatic logic [ByteW-1:0] grid_number(input logic sel_in, input int pos);
    logic [ByteW-1:0] grid;
    case (pos)
      0:       grid = sel_in ? 8'd5 : 8'd2;
      1:       grid = sel_in ? 8'd3 : 8'd1;
      default: grid = sel_in ? 8'd4 : 8'd0;
    endcase
    return grid;
  endfunction

  task automatic push_frame(input logic [VoltW-1:0] volts, input logic sel_in);
    int               hund;
    int               tens;
    int               units;
    logic [ByteW-1:0] segs [3];
    hund  = volts / 100;
    tens  = (volts / 10) % 10;
    units = volts % 10;
    segs[0] = seg_pattern(hund);
    segs[1] = seg_pattern(tens);
    segs[2] = seg_pattern(units);
    // blank leading zeros; units always shown
    if (hund == 0) begin
      segs[0] = BlankSegs;
      if (tens == 0) segs[1] = BlankSegs;
    end
    frame_beats_q.push_back('{data: fixed_cmd, start_b: 1'b1, stop_a: 1'b1, last: 1'b0});
    for (int pos = 0; pos < 3; pos++) begin
      frame_beats_q.push_back('{data: GridCmdBase | grid_number(sel_in, pos),
                                start_b: 1'b1, stop_a: 1'b0, last: 1'b0});
      frame_beats_q.push_back('{data: segs[pos], start_b: 1'b0, stop_a: 1'b1, last: 1'b0});
    end
    frame_beats_q.push_back('{data: CtrlCmdBase + {5'd0, brightness},
                              start_b: 1'b1, stop_a: 1'b1, last: 1'b1});
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bus_beat_t want;
    if (!rst_ni) begin
      brightness = BrightnessRst;
      fixed_cmd  = FixedAddrRst;
      frame_beats_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgBrightness) brightness = cfg_wdata_i[BrightW-1:0];
        else fixed_cmd = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (frame_beats_q.size() == 0) begin
          report_mismatch("unexpected beat", bus_byte_i, 0);
        end else begin
          want = frame_beats_q.pop_front();
          if (bus_byte_i !== want.data)
            report_mismatch("bus_byte", bus_byte_i, want.data);
          if (start_before_i !== want.start_b)
            report_mismatch("start_before", start_before_i, want.start_b);
          if (stop_after_i !== want.stop_a)
            report_mismatch("stop_after", stop_after_i, want.stop_a);
          if (last_byte_i !== want.last)
            report_mismatch("last_byte", last_byte_i, want.last);
        end
      end
      // out-of-range voltages are taken but produce no frame
      if (in_valid_i && in_ready_i && voltage_i <= VoltMax)
        push_frame(voltage_i, screen_select_i);
    end
    pending_o <= frame_beats_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top: clock, reset, voltage and config stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import vsfb_pkg::*;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             cfg_we      = 1'b0;
  logic             cfg_idx     = CfgBrightness;
  logic [ByteW-1:0] cfg_wdata   = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [VoltW-1:0] voltage     = '0;
  logic             screen_sel  = 1'b0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic [ByteW-1:0] bus_byte;
  logic             start_before;
  logic             stop_after;
  logic             last_byte;

  int               fail_count;
  int               beats_pending;
  int               burst_left  = 0;
  int               ready_mode  = 0;
  int               stall_left  = 0;
  int               cycle_cnt   = 0;

  logic [VoltW-1:0] corner_volts [18] = '{
    10'd0, 10'd0, 10'd7, 10'd10, 10'd19, 10'd99, 10'd100, 10'd101, 10'd110,
    10'd234, 10'd567, 10'd890, 10'd999, 10'd999, 10'd1000, 10'd1023, 10'd512, 10'd405
  };

  voltage_segment_frame_builder_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .voltage_i       (voltage),
    .screen_select_i (screen_sel),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .bus_byte_o      (bus_byte),
    .start_before_o  (start_before),
    .stop_after_o    (stop_after),
    .last_byte_o     (last_byte)
  );

  vsfb_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .voltage_i       (voltage),
    .screen_select_i (screen_sel),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .bus_byte_i      (bus_byte),
    .start_before_i  (start_before),
    .stop_after_i    (stop_after),
    .last_byte_i     (last_byte),
    .fail_count_o    (fail_count),
    .pending_o       (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: out_ready follows a stall pattern that is re-picked at random
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 97 == 96) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          out_ready  <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  task automatic send_item(input logic [VoltW-1:0] volts, input logic sel_in);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid   <= 1'b1;
    voltage    <= volts;
    screen_sel <= sel_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Hold the sender until every frame beat is out, then let a dropped item settle
  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ByteW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VoltW-1:0] pick_voltage();
    logic [VoltW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 10'($urandom_range(1000, 1023));
      1:       v = 10'($urandom_range(0, 9));
      2:       v = 10'($urandom_range(10, 99));
      3: begin
        case ($urandom_range(0, 3))
          0:       v = 10'd0;
          1:       v = 10'd999;
          2:       v = 10'd100;
          default: v = 10'd1023;
        endcase
      end
      default: v = 10'($urandom_range(0, 999));
    endcase
    return v;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // corners under reset register values
    for (int i = 0; i < 18; i++) send_item(corner_volts[i], i[0]);

    for (int phase = 0; phase < 5; phase++) begin
      drain_frames();
      case (phase)
        0: begin
          write_reg(CfgBrightness, 8'hF8);
          write_reg(CfgFixedAddr, 8'h00);
        end
        1: begin
          write_reg(CfgBrightness, 8'h07);
          write_reg(CfgFixedAddr, 8'hFF);
        end
        default: begin
          write_reg(CfgBrightness, 8'($urandom_range(0, 255)));
          write_reg(CfgFixedAddr, 8'($urandom_range(0, 255)));
        end
      endcase
      for (int k = 0; k < 50; k++) begin
        if (k == 25) drain_frames();
        send_item(pick_voltage(), 1'($urandom_range(0, 1)));
      end
    end

    drain_frames();
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/vsfb_pkg.sv
rtl/core/vsfb_digit_split.sv
rtl/core/voltage_segment_frame_builder_core.sv
dv/vsfb_checker.sv
dv/tb.sv
